FILE: sv/ubx_frame_parser_top_macros.svh
// Assertion macros for the frame parser.
// Each macro checks one implication on the rising edge of the given clock,
// and is disabled while the active-low reset is asserted.
`ifndef UBX_FRAME_PARSER_TOP_MACROS_SVH
`define UBX_FRAME_PARSER_TOP_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication.
`define UBX_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ubx_frame_parser: same-cycle check failed");

// Next-cycle implication.
`define UBX_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ubx_frame_parser: next-cycle check failed");

`else

`define UBX_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define UBX_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: sv/ubx_fp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ubx_fp_pkg;

  // Payload store geometry.
  localparam int PAYLOAD_DEPTH = 128;
  localparam int ADDR_W        = $clog2(PAYLOAD_DEPTH);
  localparam int POS_W         = $clog2(PAYLOAD_DEPTH + 1);
  localparam int LEN_W         = 16;
  localparam int SKIP_W        = LEN_W + 1;

  // Bytes of checksum that follow the payload.
  localparam logic [SKIP_W-1:0] CHECK_BYTES = SKIP_W'(2);

  // Operation codes.
  localparam logic OP_FEED = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Event codes reported with each beat.
  localparam logic [1:0] EV_NONE     = 2'd0;
  localparam logic [1:0] EV_FRAME    = 2'd1;
  localparam logic [1:0] EV_CKERR    = 2'd2;
  localparam logic [1:0] EV_OVERSIZE = 2'd3;

  // Configuration register indexes.
  localparam logic CFG_SYNC_FIRST  = 1'b0;
  localparam logic CFG_SYNC_SECOND = 1'b1;

  // Result fields decided when a beat is accepted.
  typedef struct packed {
    logic [1:0] event_res;
    logic [7:0] frame_class;
    logic [7:0] frame_msg;
    logic [7:0] frame_len;
    logic       rd_sel;
  } result_t;

endpackage

`default_nettype wire

FILE: sv/ubx_fp_ram.sv
`timescale 1ns / 1ps
`default_nettype none

// Simple dual-port RAM, one write port and one registered read port.
module ubx_fp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; data holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: sv/ubx_frame_parser_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel | Direction | Fields
// in_     | input     | operation, data_byte, read_index
// out_    | output    | event_res, frame_class, frame_msg, frame_len, read_data
// cfg_    | input     | we, index, data (sync_first, sync_second)
//
// One beat is accepted per cycle while in_ready; results go via the middle stage to the port.
// The parser state updates in the accept cycle; the payload RAM is written or read
// then, and its registered read data is merged into the output register.
// Reset is synchronous and active low; the payload RAM has no reset.
// A stalled output holds one result in the middle stage and one at the port.

module ubx_frame_parser_top (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       in_operation,
  input  wire logic [7:0] in_data_byte,
  input  wire logic [6:0] in_read_index,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic      [1:0] out_event_res,
  output logic      [7:0] out_frame_class,
  output logic      [7:0] out_frame_msg,
  output logic      [7:0] out_frame_len,
  output logic      [7:0] out_read_data,
  input  wire logic       cfg_we,
  input  wire logic       cfg_index,
  input  wire logic [7:0] cfg_data
);

  localparam int AW = ubx_fp_pkg::ADDR_W;
  localparam int PW = ubx_fp_pkg::POS_W;
  localparam int LW = ubx_fp_pkg::LEN_W;
  localparam int SW = ubx_fp_pkg::SKIP_W;

  // Parser phases.
  localparam logic [2:0] PH_SYNC1   = 3'd0;
  localparam logic [2:0] PH_SYNC2   = 3'd1;
  localparam logic [2:0] PH_HEADER  = 3'd2;
  localparam logic [2:0] PH_PAYLOAD = 3'd3;
  localparam logic [2:0] PH_CHECK   = 3'd4;
  localparam logic [2:0] PH_SKIP    = 3'd5;

  logic [7:0]    sync_first_r, sync_second_r;
  logic [2:0]    phase_r, phase_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic [7:0]    class_r, class_nxt;
  logic [7:0]    msg_r, msg_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic [7:0]    sum_a_r, sum_a_nxt;
  logic [7:0]    sum_b_r, sum_b_nxt;
  logic [7:0]    ck_a_r, ck_a_nxt;
  logic [SW-1:0] skip_r, skip_nxt;

  logic                s1_valid_r;
  ubx_fp_pkg::result_t s1_res_r, res_nxt;
  logic                out_valid_r;
  logic [1:0]          out_event_r;
  logic [7:0]          out_class_r, out_msg_r, out_len_r, out_rd_r;

  logic          accept, advance;
  logic          is_feed, ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_q;
  logic [7:0]    hsum_a, hsum_b;
  logic [LW-1:0] new_len;

  // Handshake: the middle stage moves on when the port register frees up.
  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;
  assign accept   = in_valid && in_ready;
  assign is_feed  = accept && (in_operation == ubx_fp_pkg::OP_FEED);

  // Running Fletcher sum with the incoming byte folded in.
  assign hsum_a  = sum_a_r + in_data_byte;
  assign hsum_b  = sum_b_r + hsum_a;
  assign new_len = {in_data_byte, len_r[7:0]};

  // Parser next state and result fields.
  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    class_nxt = class_r;
    msg_nxt   = msg_r;
    len_nxt   = len_r;
    sum_a_nxt = sum_a_r;
    sum_b_nxt = sum_b_r;
    ck_a_nxt  = ck_a_r;
    skip_nxt  = skip_r;
    ram_we    = 1'b0;
    res_nxt   = '{event_res: ubx_fp_pkg::EV_NONE, frame_class: 8'd0, frame_msg: 8'd0,
                  frame_len: 8'd0, rd_sel: 1'b0};
    if (accept && (in_operation == ubx_fp_pkg::OP_READ)) begin
      res_nxt.rd_sel = (int'(in_read_index) < ubx_fp_pkg::PAYLOAD_DEPTH);
    end
    if (is_feed) begin
      case (phase_r)
        PH_SYNC1: begin
          if (in_data_byte == sync_first_r) begin
            phase_nxt = PH_SYNC2;
          end
        end
        PH_SYNC2: begin
          // The second-sync test wins when both registers match.
          if (in_data_byte == sync_second_r) begin
            phase_nxt = PH_HEADER;
            pos_nxt   = '0;
            sum_a_nxt = 8'd0;
            sum_b_nxt = 8'd0;
          end else if (in_data_byte != sync_first_r) begin
            phase_nxt = PH_SYNC1;
          end
        end
        PH_HEADER: begin
          sum_a_nxt = hsum_a;
          sum_b_nxt = hsum_b;
          pos_nxt   = pos_r + PW'(1);
          case (pos_r[1:0])
            2'd0:    class_nxt = in_data_byte;
            2'd1:    msg_nxt   = in_data_byte;
            2'd2:    len_nxt   = LW'(in_data_byte);
            default: begin
              len_nxt = new_len;
              pos_nxt = '0;
              if (new_len > LW'(ubx_fp_pkg::PAYLOAD_DEPTH)) begin
                skip_nxt          = SW'(new_len) + ubx_fp_pkg::CHECK_BYTES;
                phase_nxt         = PH_SKIP;
                res_nxt.event_res = ubx_fp_pkg::EV_OVERSIZE;
              end else if (new_len == '0) begin
                phase_nxt = PH_CHECK;
              end else begin
                phase_nxt = PH_PAYLOAD;
              end
            end
          endcase
        end
        PH_PAYLOAD: begin
          sum_a_nxt = hsum_a;
          sum_b_nxt = hsum_b;
          ram_we    = 1'b1;
          pos_nxt   = pos_r + PW'(1);
          if (LW'(pos_r) + LW'(1) >= len_r) begin
            pos_nxt   = '0;
            phase_nxt = PH_CHECK;
          end
        end
        PH_CHECK: begin
          if (pos_r == '0) begin
            ck_a_nxt = in_data_byte;
            pos_nxt  = PW'(1);
          end else begin
            if (ck_a_r == sum_a_r && in_data_byte == sum_b_r) begin
              res_nxt.event_res   = ubx_fp_pkg::EV_FRAME;
              res_nxt.frame_class = class_r;
              res_nxt.frame_msg   = msg_r;
              res_nxt.frame_len   = len_r[7:0];
            end else begin
              res_nxt.event_res = ubx_fp_pkg::EV_CKERR;
            end
            phase_nxt = PH_SYNC1;
            pos_nxt   = '0;
          end
        end
        PH_SKIP: begin
          if (skip_r <= SW'(1)) begin
            skip_nxt  = '0;
            phase_nxt = PH_SYNC1;
            pos_nxt   = '0;
          end else begin
            skip_nxt = skip_r - SW'(1);
          end
        end
        default: begin
          phase_nxt = PH_SYNC1;
          pos_nxt   = '0;
        end
      endcase
    end
  end

  // Payload store access.
  assign ram_waddr = pos_r[AW-1:0];
  assign ram_re    = accept && (in_operation == ubx_fp_pkg::OP_READ);
  assign ram_raddr = AW'(in_read_index);

  ubx_fp_ram #(
    .WIDTH(8),
    .DEPTH(ubx_fp_pkg::PAYLOAD_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(in_data_byte),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_q)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_first_r  <= 8'd181;
      sync_second_r <= 8'd98;
    end else if (cfg_we) begin
      if (cfg_index == ubx_fp_pkg::CFG_SYNC_FIRST) begin
        sync_first_r <= cfg_data;
      end else begin
        sync_second_r <= cfg_data;
      end
    end
  end

  // Parser state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SYNC1;
      pos_r   <= '0;
      class_r <= 8'd0;
      msg_r   <= 8'd0;
      len_r   <= '0;
      sum_a_r <= 8'd0;
      sum_b_r <= 8'd0;
      ck_a_r  <= 8'd0;
      skip_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      class_r <= class_nxt;
      msg_r   <= msg_nxt;
      len_r   <= len_nxt;
      sum_a_r <= sum_a_nxt;
      sum_b_r <= sum_b_nxt;
      ck_a_r  <= ck_a_nxt;
      skip_r  <= skip_nxt;
    end
  end

  // Middle stage: waits for the RAM read data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_res_r <= res_nxt;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_event_r <= s1_res_r.event_res;
      out_class_r <= s1_res_r.frame_class;
      out_msg_r   <= s1_res_r.frame_msg;
      out_len_r   <= s1_res_r.frame_len;
      out_rd_r    <= s1_res_r.rd_sel ? ram_q : 8'd0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_event_res   = out_event_r;
  assign out_frame_class = out_class_r;
  assign out_frame_msg   = out_msg_r;
  assign out_frame_len   = out_len_r;
  assign out_read_data   = out_rd_r;

`include "ubx_frame_parser_top_macros.svh"

  // The payload position never reaches the announced length inside the payload.
  `UBX_ASSERT_SAME(a_pos_below_len, clk, rst_n, phase_r == PH_PAYLOAD, LW'(pos_r) < len_r)
  // The header counter stays within the four header bytes.
  `UBX_ASSERT_SAME(a_header_pos, clk, rst_n, phase_r == PH_HEADER, pos_r < PW'(4))
  // A read beat never carries a parser event.
  `UBX_ASSERT_SAME(a_read_no_event, clk, rst_n, s1_valid_r && s1_res_r.rd_sel,
                   s1_res_r.event_res == ubx_fp_pkg::EV_NONE)
  // An accepted beat always lands in the middle stage.
  `UBX_ASSERT_NEXT(a_accept_fills, clk, rst_n, accept, s1_valid_r)

endmodule

`default_nettype wire

FILE: bench/ubx_frame_parser_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the frame parser, predicts the result of every
// accepted input beat and compares each result beat with the oldest prediction.
module ubx_frame_parser_checker (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  input  logic                                 in_ready,
  input  logic                                 in_operation,
  input  logic [7:0]                           in_data_byte,
  input  logic [6:0]                           in_read_index,
  input  logic                                 out_valid,
  input  logic                                 out_ready,
  input  logic [1:0]                           out_event_res,
  input  logic [7:0]                           out_frame_class,
  input  logic [7:0]                           out_frame_msg,
  input  logic [7:0]                           out_frame_len,
  input  logic [7:0]                           out_read_data,
  input  logic                                 cfg_we,
  input  logic                                 cfg_index,
  input  logic [7:0]                           cfg_data,
  output int                                   fail_count,
  output int                                   pending,
  output logic [ubx_fp_pkg::PAYLOAD_DEPTH-1:0] stored_mask
);

  typedef enum logic [2:0] {
    HUNT_SYNC1,
    HUNT_SYNC2,
    GET_HEADER,
    GET_PAYLOAD,
    GET_CHECK,
    SKIP_FRAME
  } deframe_phase_t;

  typedef struct packed {
    logic [1:0] event_res;
    logic [7:0] frame_class;
    logic [7:0] frame_msg;
    logic [7:0] frame_len;
    logic [7:0] read_data;
  } beat_result_t;

  // Shadow copy of the parser state and its two sync registers.
  logic [7:0]                           sync_first_q;
  logic [7:0]                           sync_second_q;
  deframe_phase_t                       phase;
  logic [7:0]                           pos;
  logic [7:0]                           cls;
  logic [7:0]                           msg;
  logic [15:0]                          ann_len;
  logic [7:0]                           sum_a;
  logic [7:0]                           sum_b;
  logic [7:0]                           check_a;
  logic [ubx_fp_pkg::SKIP_W-1:0]        skip_left;
  logic [7:0]                           payload_mem [ubx_fp_pkg::PAYLOAD_DEPTH];
  logic [ubx_fp_pkg::PAYLOAD_DEPTH-1:0] written;

  beat_result_t beat_results_q[$];
  int           errs;

  // Advances the shadow parser by one input beat and returns the result it causes.
  function automatic beat_result_t deframe_beat(input logic op, input logic [7:0] b,
                                                input logic [6:0] idx);
    beat_result_t r;
    r = '0;
    if (op == ubx_fp_pkg::OP_READ) begin
      r.read_data = payload_mem[idx];
    end else begin
      case (phase)
        HUNT_SYNC1: begin
          if (b == sync_first_q) phase = HUNT_SYNC2;
        end
        HUNT_SYNC2: begin
          // The second-sync test wins when both sync registers are equal.
          if (b == sync_second_q) begin
            phase = GET_HEADER;
            pos   = '0;
            sum_a = '0;
            sum_b = '0;
          end else if (b != sync_first_q) begin
            phase = HUNT_SYNC1;
          end
        end
        GET_HEADER: begin
          sum_a = sum_a + b;
          sum_b = sum_b + sum_a;
          case (pos)
            8'd0:    cls = b;
            8'd1:    msg = b;
            8'd2:    ann_len = {8'h00, b};
            default: ann_len = {b, ann_len[7:0]};
          endcase
          pos = pos + 8'd1;
          if (pos == 8'd4) begin
            pos = '0;
            if (ann_len > ubx_fp_pkg::PAYLOAD_DEPTH) begin
              skip_left   = {1'b0, ann_len} + ubx_fp_pkg::CHECK_BYTES;
              phase       = SKIP_FRAME;
              r.event_res = ubx_fp_pkg::EV_OVERSIZE;
            end else begin
              phase = (ann_len == 16'd0) ? GET_CHECK : GET_PAYLOAD;
            end
          end
        end
        GET_PAYLOAD: begin
          sum_a = sum_a + b;
          sum_b = sum_b + sum_a;
          if (pos < ubx_fp_pkg::PAYLOAD_DEPTH) begin
            payload_mem[pos[ubx_fp_pkg::ADDR_W-1:0]] = b;
            written[pos[ubx_fp_pkg::ADDR_W-1:0]]     = 1'b1;
          end
          pos = pos + 8'd1;
          if (pos >= ann_len) begin
            pos   = '0;
            phase = GET_CHECK;
          end
        end
        GET_CHECK: begin
          if (pos == 8'd0) begin
            check_a = b;
            pos     = 8'd1;
          end else begin
            if (check_a == sum_a && b == sum_b) begin
              r.event_res   = ubx_fp_pkg::EV_FRAME;
              r.frame_class = cls;
              r.frame_msg   = msg;
              r.frame_len   = ann_len[7:0];
            end else begin
              r.event_res = ubx_fp_pkg::EV_CKERR;
            end
            phase = HUNT_SYNC1;
            pos   = '0;
          end
        end
        SKIP_FRAME: begin
          if (skip_left != '0) skip_left = skip_left - 1'b1;
          if (skip_left == '0) begin
            phase = HUNT_SYNC1;
            pos   = '0;
          end
        end
        default: begin
          phase = HUNT_SYNC1;
          pos   = '0;
        end
      endcase
    end
    return r;
  endfunction

  task automatic note_mismatch(input string what, input logic [7:0] want,
                               input logic [7:0] got);
    errs++;
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
  endtask

  // Prediction on input beats, comparison on result beats.
  always @(posedge clk) begin
    beat_result_t want;
    if (!rst_n) begin
      sync_first_q  = 8'd181;
      sync_second_q = 8'd98;
      phase         = HUNT_SYNC1;
      pos           = '0;
      cls           = '0;
      msg           = '0;
      ann_len       = '0;
      sum_a         = '0;
      sum_b         = '0;
      check_a       = '0;
      skip_left     = '0;
      written       = '0;
      errs          = 0;
      beat_results_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == ubx_fp_pkg::CFG_SYNC_FIRST) sync_first_q = cfg_data;
        else sync_second_q = cfg_data;
      end
      if (in_valid && in_ready) begin
        beat_results_q.push_back(deframe_beat(in_operation, in_data_byte, in_read_index));
      end
      if (out_valid && out_ready) begin
        if (beat_results_q.size() == 0) begin
          errs++;
          $display("%0t: result beat arrived with none expected", $time);
        end else begin
          want = beat_results_q.pop_front();
          if (out_event_res !== want.event_res)
            note_mismatch("event_res", want.event_res, out_event_res);
          if (out_frame_class !== want.frame_class)
            note_mismatch("frame_class", want.frame_class, out_frame_class);
          if (out_frame_msg !== want.frame_msg)
            note_mismatch("frame_msg", want.frame_msg, out_frame_msg);
          if (out_frame_len !== want.frame_len)
            note_mismatch("frame_len", want.frame_len, out_frame_len);
          if (out_read_data !== want.read_data)
            note_mismatch("read_data", want.read_data, out_read_data);
        end
      end
    end
    fail_count  <= errs;
    pending     <= beat_results_q.size();
    stored_mask <= written;
  end

endmodule

FILE: bench/tb_ubx_frame_parser_top.sv
`timescale 1ns / 1ps

module tb_ubx_frame_parser_top;

  // Ways to spoil the checksum of a generated frame.
  localparam int CK_GOOD  = 0;
  localparam int CK_BAD_A = 1;
  localparam int CK_BAD_B = 2;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic       in_operation;
  logic [7:0] in_data_byte;
  logic [6:0] in_read_index;
  logic       out_valid;
  logic       out_ready;
  logic [1:0] out_event_res;
  logic [7:0] out_frame_class;
  logic [7:0] out_frame_msg;
  logic [7:0] out_frame_len;
  logic [7:0] out_read_data;
  logic       cfg_we;
  logic       cfg_index;
  logic [7:0] cfg_data;

  int                                   fail_count;
  int                                   pending;
  logic [ubx_fp_pkg::PAYLOAD_DEPTH-1:0] stored_mask;

  int         snd_idle_pct = 9;
  int         rcv_idle_pct = 45;
  int         items_sent   = 0;
  logic [7:0] cur_sync1;
  logic [7:0] cur_sync2;

  ubx_frame_parser_top u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_operation    (in_operation),
    .in_data_byte    (in_data_byte),
    .in_read_index   (in_read_index),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_event_res   (out_event_res),
    .out_frame_class (out_frame_class),
    .out_frame_msg   (out_frame_msg),
    .out_frame_len   (out_frame_len),
    .out_read_data   (out_read_data),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  ubx_frame_parser_checker u_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_operation    (in_operation),
    .in_data_byte    (in_data_byte),
    .in_read_index   (in_read_index),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_event_res   (out_event_res),
    .out_frame_class (out_frame_class),
    .out_frame_msg   (out_frame_msg),
    .out_frame_len   (out_frame_len),
    .out_read_data   (out_read_data),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .fail_count      (fail_count),
    .pending         (pending),
    .stored_mask     (stored_mask)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // The receiver stalls at random at the current rate.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
  end

  // Drives one input beat, idling first at random, and holds it until accepted.
  task automatic send_item(input logic op, input logic [7:0] b, input logic [6:0] idx,
                           input bit counted);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_operation  <= op;
    in_data_byte  <= b;
    in_read_index <= idx;
    do @(posedge clk); while (!in_ready);
    if (counted) items_sent++;
  endtask

  // Feeds one byte, sometimes preceded by a read of a payload entry already written.
  task automatic send_byte(input logic [7:0] b, input bit counted);
    logic [6:0] idx;
    idx = 7'($urandom_range(0, ubx_fp_pkg::PAYLOAD_DEPTH - 1));
    if ($urandom_range(0, 99) < 8 && stored_mask[idx]) begin
      send_item(ubx_fp_pkg::OP_READ, 8'($urandom), idx, 1'b1);
    end
    send_item(ubx_fp_pkg::OP_FEED, b, 7'($urandom), counted);
  endtask

  // Sends a complete frame with random payload. Oversize frames are followed by
  // the filler bytes the parser drops without looking at them.
  task automatic send_frame(input logic [7:0] cls, input logic [7:0] msg,
                            input logic [15:0] len, input int ck_fault);
    logic [7:0] hdr [4];
    logic [7:0] ck_a;
    logic [7:0] ck_b;
    logic [7:0] b;
    ck_a   = '0;
    ck_b   = '0;
    hdr[0] = cls;
    hdr[1] = msg;
    hdr[2] = len[7:0];
    hdr[3] = len[15:8];
    send_byte(cur_sync1, 1'b1);
    send_byte(cur_sync2, 1'b1);
    foreach (hdr[i]) begin
      ck_a = ck_a + hdr[i];
      ck_b = ck_b + ck_a;
      send_byte(hdr[i], 1'b1);
    end
    if (len > ubx_fp_pkg::PAYLOAD_DEPTH) begin
      repeat (int'(len) + 2) send_byte(8'($urandom), 1'b1);
    end else begin
      repeat (int'(len)) begin
        b    = 8'($urandom);
        ck_a = ck_a + b;
        ck_b = ck_b + ck_a;
        send_byte(b, 1'b1);
      end
      if (ck_fault == CK_BAD_A) ck_a = ck_a ^ 8'($urandom_range(1, 255));
      if (ck_fault == CK_BAD_B) ck_b = ck_b ^ 8'($urandom_range(1, 255));
      send_byte(ck_a, 1'b1);
      send_byte(ck_b, 1'b1);
    end
  endtask

  // Lowers valid and waits until every predicted result beat has come back.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_syncs(input logic [7:0] s1, input logic [7:0] s2);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= ubx_fp_pkg::CFG_SYNC_FIRST;
    cfg_data  <= s1;
    @(posedge clk);
    cfg_index <= ubx_fp_pkg::CFG_SYNC_SECOND;
    cfg_data  <= s2;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_sync1 = s1;
    cur_sync2 = s2;
  endtask

  // Mostly well-formed frames with random content, plus noise, broken preambles
  // and read bursts, until the running item count reaches the target.
  task automatic run_random(input int target);
    int          pick;
    int          k;
    int          fault;
    logic [15:0] len;
    logic [7:0]  b;
    while (items_sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        k = $urandom_range(0, 99);
        if (k < 85) len = 16'($urandom_range(0, 12));
        else if (k < 95) len = 16'($urandom_range(13, ubx_fp_pkg::PAYLOAD_DEPTH));
        else len = 16'(ubx_fp_pkg::PAYLOAD_DEPTH);
        k = $urandom_range(0, 99);
        fault = (k < 80) ? CK_GOOD : (k < 90) ? CK_BAD_A : CK_BAD_B;
        send_frame(8'($urandom), 8'($urandom), len, fault);
      end else if (pick < 78) begin
        len = 16'($urandom_range(ubx_fp_pkg::PAYLOAD_DEPTH + 1,
                                 ubx_fp_pkg::PAYLOAD_DEPTH + 40));
        send_frame(8'($urandom), 8'($urandom), len, CK_GOOD);
      end else if (pick < 88) begin
        // Noise never holds the second sync byte, so no stray frame can start.
        repeat ($urandom_range(1, 4)) begin
          b = ($urandom_range(0, 3) == 0) ? cur_sync1 : 8'($urandom);
          if (b == cur_sync2) b = ~b;
          send_byte(b, 1'b1);
        end
      end else if (pick < 94) begin
        // A preamble that breaks off after one or more first sync bytes.
        repeat ($urandom_range(1, 3)) send_byte(cur_sync1, 1'b1);
        do b = 8'($urandom); while (b == cur_sync1 || b == cur_sync2);
        send_byte(b, 1'b1);
      end else begin
        repeat ($urandom_range(1, 3)) begin
          k = $urandom_range(0, ubx_fp_pkg::PAYLOAD_DEPTH - 1);
          if (stored_mask[k]) send_item(ubx_fp_pkg::OP_READ, 8'($urandom), 7'(k), 1'b1);
        end
      end
    end
  endtask

  initial begin
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_operation  <= ubx_fp_pkg::OP_FEED;
    in_data_byte  <= '0;
    in_read_index <= '0;
    out_ready     <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_index     <= ubx_fp_pkg::CFG_SYNC_FIRST;
    cfg_data      <= '0;
    cur_sync1     = 8'd181;
    cur_sync2     = 8'd98;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed beats with the default preamble.
    set_syncs(8'd181, 8'd98);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    // An extra first sync byte ahead of a zero-length frame.
    send_byte(cur_sync1, 1'b1);
    send_frame(8'hFF, 8'h00, 16'd0, CK_GOOD);
    send_frame(8'h00, 8'hFF, 16'd3, CK_BAD_B);
    send_frame(8'h01, 8'h02, 16'd2, CK_BAD_A);
    send_item(ubx_fp_pkg::OP_READ, 8'h00, 7'd0, 1'b1);
    send_item(ubx_fp_pkg::OP_READ, 8'hFF, 7'd2, 1'b1);
    send_byte(cur_sync1, 1'b1);
    send_byte(8'h11, 1'b1);
    send_frame(8'h0C, 8'h0D, 16'h0100, CK_GOOD);

    // Both sync registers equal.
    set_syncs(8'h3C, 8'h3C);
    send_frame(8'h3C, 8'h3C, 16'd1, CK_GOOD);

    // Random part, sender idling lightly and receiver heavily.
    set_syncs(8'h00, 8'hFF);
    snd_idle_pct = 9;
    rcv_idle_pct = 45;
    send_frame(8'h55, 8'hAA, 16'(ubx_fp_pkg::PAYLOAD_DEPTH), CK_GOOD);
    send_item(ubx_fp_pkg::OP_READ, 8'h00, 7'd127, 1'b1);
    send_item(ubx_fp_pkg::OP_READ, 8'hFF, 7'd0, 1'b1);
    run_random(540);

    // The other way round.
    set_syncs(8'hFF, 8'h00);
    snd_idle_pct = 45;
    rcv_idle_pct = 9;
    run_random(640);

    // No idling on either side.
    set_syncs(8'd181, 8'd98);
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    run_random(740);

    wait_idle();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
